FILE: sv/pcrc_pkg.sv
// Package for the programmable CRC divider.
// Holds register indexes, widths and the shared configuration struct.
// No dependencies.
package pcrc_pkg;

  // Largest supported divisor degree, and the width of the remainder path.
  localparam int MAX_DEGREE = 32;
  localparam int REM_W      = 32;
  localparam int DEG_W      = 6;
  localparam int IDX_W      = 5;

  // Configuration register indexes.
  localparam logic REG_POLY   = 1'b0;
  localparam logic REG_DEGREE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [REM_W-1:0] POLY_RESET   = 32'd3;
  localparam logic [DEG_W-1:0] DEGREE_RESET = 6'd3;

  // Decoded configuration handed to the division step.
  typedef struct packed {
    logic [REM_W-1:0] mask;
    logic [REM_W-1:0] poly;
    logic [IDX_W-1:0] top_idx;
  } cfg_t;

endpackage

FILE: sv/pcrc_cfg.sv
// Configuration registers of the programmable CRC divider.
// Stores the polynomial and degree and decodes the degree mask.
// Depends on pcrc_pkg.
module pcrc_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic                      wr_index,
  input  logic [pcrc_pkg::REM_W-1:0] wr_data,
  output pcrc_pkg::cfg_t            cfg
);

  logic [pcrc_pkg::REM_W-1:0] poly_low_bits;
  logic [pcrc_pkg::DEG_W-1:0] crc_degree;
  logic [pcrc_pkg::DEG_W-1:0] eff_degree;
  logic [pcrc_pkg::DEG_W-1:0] top_pos;

  // Register writes; the index selects one of the two registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      poly_low_bits <= pcrc_pkg::POLY_RESET;
      crc_degree    <= pcrc_pkg::DEGREE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        pcrc_pkg::REG_POLY:   poly_low_bits <= wr_data;
        pcrc_pkg::REG_DEGREE: crc_degree    <= wr_data[pcrc_pkg::DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // A degree of zero acts as one; a degree above the maximum saturates.
  always_comb begin
    if (crc_degree == '0) begin
      eff_degree = pcrc_pkg::DEG_W'(1);
    end else if (crc_degree > pcrc_pkg::DEG_W'(pcrc_pkg::MAX_DEGREE)) begin
      eff_degree = pcrc_pkg::DEG_W'(pcrc_pkg::MAX_DEGREE);
    end else begin
      eff_degree = crc_degree;
    end
    top_pos     = eff_degree - pcrc_pkg::DEG_W'(1);
    cfg.mask    = ~({pcrc_pkg::REM_W{1'b1}} << eff_degree);
    cfg.poly    = poly_low_bits & cfg.mask;
    cfg.top_idx = top_pos[pcrc_pkg::IDX_W-1:0];
  end

endmodule

FILE: sv/pcrc_step.sv
// One modulo-2 division step of the programmable CRC divider.
// Holds the running remainder and computes the next one per bit.
// Depends on pcrc_pkg.
module pcrc_step (
  input  logic                       clk,
  input  logic                       rst,
  input  pcrc_pkg::cfg_t             cfg,
  input  logic                       advance,
  input  logic                       data_bit,
  input  logic                       last_bit,
  output logic                       quotient_bit,
  output logic [pcrc_pkg::REM_W-1:0] remainder_value,
  output logic                       remainder_is_zero
);

  logic [pcrc_pkg::REM_W-1:0] remainder_reg;
  logic [pcrc_pkg::REM_W-1:0] remainder_reg_next;
  logic [pcrc_pkg::REM_W-1:0] rem_masked;

  // Feedback is the data bit against the remainder's top bit.
  always_comb begin
    rem_masked        = remainder_reg & cfg.mask;
    quotient_bit      = data_bit ^ rem_masked[cfg.top_idx];
    remainder_value   = ((rem_masked << 1) & cfg.mask) ^
                        (quotient_bit ? cfg.poly : '0);
    remainder_is_zero = (remainder_value == '0);
    remainder_reg_next = last_bit ? '0 : remainder_value;
  end

  // The remainder moves only when a bit is consumed; it clears after the last bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder_reg <= '0;
    end else if (advance) begin
      remainder_reg <= remainder_reg_next;
    end
  end

endmodule

FILE: sv/programmable_crc_divider.sv
// Programmable CRC divider: one input bit in, one division result out.
// A request is taken into the input register, then into the output register.
// Unstalled throughput: one bit per cycle, set by the single XOR-shift between them.
// Reset (rst, synchronous) empties both stages, clears the remainder and
// restores the polynomial and degree registers to 3.
// Depends on pcrc_pkg, pcrc_cfg and pcrc_step.
module programmable_crc_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic                       wr_index,
  input  logic [pcrc_pkg::REM_W-1:0] wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       data_bit,
  input  logic                       last_bit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       quotient_bit,
  output logic [pcrc_pkg::REM_W-1:0] remainder_value,
  output logic                       remainder_is_zero,
  output logic                       message_end
);

  pcrc_pkg::cfg_t cfg;

  logic                       s1_valid;
  logic                       s1_data;
  logic                       s1_last;
  logic                       s2_ready;
  logic                       s1_advance;
  logic                       step_quotient;
  logic [pcrc_pkg::REM_W-1:0] step_remainder;
  logic                       step_zero;

  pcrc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Stage handshakes: the output register frees when empty or taken.
  assign s2_ready   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && s2_ready;
  assign in_stall   = s1_valid && !s2_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= data_bit;
      s1_last <= last_bit;
    end
  end

  pcrc_step u_step (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .advance           (s1_advance),
    .data_bit          (s1_data),
    .last_bit          (s1_last),
    .quotient_bit      (step_quotient),
    .remainder_value   (step_remainder),
    .remainder_is_zero (step_zero)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      quotient_bit      <= step_quotient;
      remainder_value   <= step_remainder;
      remainder_is_zero <= step_zero;
      message_end       <= s1_last;
    end
  end

endmodule

FILE: sv/pcrc_checker.sv
// Port-level checker for the programmable CRC divider, with its bind.
// Watches the handshakes and result fields of programmable_crc_divider.
// Depends on pcrc_pkg.
module pcrc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       quotient_bit,
  input logic [pcrc_pkg::REM_W-1:0] remainder_value,
  input logic                       remainder_is_zero,
  input logic                       message_end
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(quotient_bit) &&
      $stable(remainder_value) && $stable(remainder_is_zero) && $stable(message_end))
    else $error("stalled result changed");

  // No result is shown in the cycle after a reset edge.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // The zero flag agrees with the remainder it describes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (remainder_is_zero == (remainder_value == '0)))
    else $error("zero flag disagrees with remainder");

  // With the output register empty, the input side never stalls.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

endmodule

bind programmable_crc_divider pcrc_checker u_pcrc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .quotient_bit      (quotient_bit),
  .remainder_value   (remainder_value),
  .remainder_is_zero (remainder_is_zero),
  .message_end       (message_end)
);

FILE: sim/crc_division_checker.sv
// Checker for the programmable CRC divider: tracks register writes, predicts
// every division step and compares the results in order of arrival.
// Depends on pcrc_pkg for widths, register indexes and reset values.
module crc_division_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic                       wr_index,
  input  logic [pcrc_pkg::REM_W-1:0] wr_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       data_bit,
  input  logic                       last_bit,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       quotient_bit,
  input  logic [pcrc_pkg::REM_W-1:0] remainder_value,
  input  logic                       remainder_is_zero,
  input  logic                       message_end,
  output int                         open_count,
  output int                         error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // One division result as the block should present it.
  typedef struct packed {
    logic                       quotient;
    logic [pcrc_pkg::REM_W-1:0] remainder;
    logic                       is_zero;
    logic                       end_flag;
  } step_result_t;

  localparam int MAX_REPORTS = 40;

  logic [pcrc_pkg::REM_W-1:0] poly_q;
  logic [pcrc_pkg::DEG_W-1:0] degree_q;
  logic [pcrc_pkg::REM_W-1:0] remainder_q;
  step_result_t               pending_results[$];
  int                         reports = 0;

  // One XOR-shift of the divider. The degree saturates to 1..MAX_DEGREE and the
  // stored remainder is trimmed to it first, so a degree change drops high bits.
  function automatic step_result_t divide_step(logic din, logic last_in);
    int unsigned                deg;
    logic [pcrc_pkg::REM_W-1:0] mask;
    logic [pcrc_pkg::REM_W-1:0] rem;
    logic                       fb;
    step_result_t               res;
    deg = degree_q;
    if (deg < 1) deg = 1;
    if (deg > pcrc_pkg::MAX_DEGREE) deg = pcrc_pkg::MAX_DEGREE;
    if (deg > pcrc_pkg::REM_W) deg = pcrc_pkg::REM_W;
    mask = {pcrc_pkg::REM_W{1'b1}} >> (pcrc_pkg::REM_W - deg);
    rem  = remainder_q & mask;
    fb   = din ^ rem[deg-1];
    rem  = (rem << 1) & mask;
    if (fb) rem = rem ^ (poly_q & mask);
    res.quotient  = fb;
    res.remainder = rem;
    res.is_zero   = (rem == '0);
    res.end_flag  = last_in;
    return res;
  endfunction

  // Count a wrong field and report it while the report budget lasts.
  task automatic check_field(string name, logic [pcrc_pkg::REM_W-1:0] want,
                             logic [pcrc_pkg::REM_W-1:0] got);
    if (got !== want) begin
      error_count++;
      if (reports < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        reports++;
      end
    end
  endtask

  // Results are checked before new requests are queued; a request's own result
  // can never leave in the cycle it is accepted.
  always @(posedge clk) begin
    step_result_t want;
    if (rst) begin
      poly_q      = pcrc_pkg::POLY_RESET;
      degree_q    = pcrc_pkg::DEGREE_RESET;
      remainder_q = '0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (reports < MAX_REPORTS) begin
            $display("%0t: unexpected result, expected none actual remainder %0h",
                     $time, remainder_value);
            reports++;
          end
        end else begin
          want = pending_results.pop_front();
          check_field("quotient_bit", pcrc_pkg::REM_W'(want.quotient),
                      pcrc_pkg::REM_W'(quotient_bit));
          check_field("remainder_value", want.remainder, remainder_value);
          check_field("remainder_is_zero", pcrc_pkg::REM_W'(want.is_zero),
                      pcrc_pkg::REM_W'(remainder_is_zero));
          check_field("message_end", pcrc_pkg::REM_W'(want.end_flag),
                      pcrc_pkg::REM_W'(message_end));
        end
      end

      // Register writes.
      if (wr_en) begin
        if (wr_index == pcrc_pkg::REG_POLY) begin
          poly_q = wr_data;
        end else begin
          degree_q = wr_data[pcrc_pkg::DEG_W-1:0];
        end
      end

      // Accepted request: predict and advance the running remainder.
      if (in_valid && !in_stall) begin
        want = divide_step(data_bit, last_bit);
        pending_results.push_back(want);
        remainder_q = last_bit ? '0 : want.remainder;
      end
    end
    open_count <= pending_results.size();
  end

endmodule

FILE: sim/tb_programmable_crc_divider.sv
// Top of the programmable CRC divider testbench: clock, reset, register
// programming, bit stimulus and receiver stalls, plus the final verdict.
// Depends on pcrc_pkg, programmable_crc_divider and crc_division_checker.
module tb_programmable_crc_divider;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       wr_en = 1'b0;
  logic                       wr_index = pcrc_pkg::REG_POLY;
  logic [pcrc_pkg::REM_W-1:0] wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       data_bit = 1'b0;
  logic                       last_bit = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       quotient_bit;
  logic [pcrc_pkg::REM_W-1:0] remainder_value;
  logic                       remainder_is_zero;
  logic                       message_end;
  int                         open_count;
  int                         error_count;

  int unsigned                gap_pct = 0;
  int unsigned                stall_pct = 0;
  int unsigned                cycle_count = 0;
  logic [pcrc_pkg::REM_W-1:0] cur_poly = pcrc_pkg::POLY_RESET;
  logic [pcrc_pkg::DEG_W-1:0] cur_degree = pcrc_pkg::DEGREE_RESET;
  bit                         msg_bits[$];

  programmable_crc_divider u_dut (.*);

  crc_division_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver side: random stall bursts at a rate set per phase.
  initial begin : receiver_stalls
    int unsigned burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (burst == 0 && $urandom_range(99, 0) < stall_pct) burst = $urandom_range(15, 1);
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Write both registers on consecutive cycles; the enable stays high between them.
  task automatic program_divider(logic [pcrc_pkg::REM_W-1:0] poly,
                                 logic [pcrc_pkg::REM_W-1:0] deg_word);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= pcrc_pkg::REG_POLY;
    wr_data  <= poly;
    @(posedge clk);
    wr_index <= pcrc_pkg::REG_DEGREE;
    wr_data  <= deg_word;
    @(posedge clk);
    wr_en    <= 1'b0;
    cur_poly   = poly;
    cur_degree = deg_word[pcrc_pkg::DEG_W-1:0];
  endtask

  // Present one bit request, possibly after a gap, and hold it until accepted.
  task automatic send_bit(logic din, logic last_in);
    if ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_bit <= din;
    last_bit <= last_in;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every outstanding result has been delivered.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Check bits that make the queued message a codeword of the current divisor.
  function automatic logic [pcrc_pkg::REM_W-1:0] crc_of_message(int unsigned deg);
    logic [pcrc_pkg::REM_W-1:0] mask;
    logic [pcrc_pkg::REM_W-1:0] rem;
    logic                       fb;
    mask = {pcrc_pkg::REM_W{1'b1}} >> (pcrc_pkg::REM_W - deg);
    rem  = '0;
    foreach (msg_bits[i]) begin
      fb  = msg_bits[i] ^ rem[deg-1];
      rem = ((rem << 1) ^ (fb ? cur_poly : '0)) & mask;
    end
    return rem;
  endfunction

  // Send a sequence of bits, the final one marked last.
  task automatic send_message(bit bits[$]);
    foreach (bits[i]) send_bit(bits[i], i == bits.size() - 1);
  endtask

  // One random phase: mostly clean codewords, some corrupted ones and some noise.
  // The phase may stop mid-message, so the next phase's degree lands on live state.
  task automatic run_phase(int unsigned count, int unsigned gaps, int unsigned stalls);
    int unsigned                sent;
    int unsigned                deg;
    int unsigned                kind;
    int unsigned                flip;
    logic [pcrc_pkg::REM_W-1:0] crc;
    gap_pct   = gaps;
    stall_pct = stalls;
    deg = (cur_degree == 0) ? 1 :
          ((cur_degree > pcrc_pkg::MAX_DEGREE) ? pcrc_pkg::MAX_DEGREE : cur_degree);
    sent = 0;
    while (sent < count) begin
      msg_bits.delete();
      kind = $urandom_range(99, 0);
      if (kind < 75) begin
        repeat ($urandom_range(12, 1)) msg_bits.push_back(1'($urandom_range(1, 0)));
        crc = crc_of_message(deg);
        for (int i = deg - 1; i >= 0; i--) msg_bits.push_back(crc[i]);
        // A single flipped bit corrupts an otherwise clean codeword.
        if (kind >= 60) begin
          flip = $urandom_range(msg_bits.size() - 1, 0);
          msg_bits[flip] = ~msg_bits[flip];
        end
      end else begin
        repeat ($urandom_range(40, 1)) msg_bits.push_back(1'($urandom_range(1, 0)));
      end
      foreach (msg_bits[i]) begin
        if (sent == count) break;
        send_bit(msg_bits[i], i == msg_bits.size() - 1);
        sent++;
        // Hold off once per phase until the pipeline is empty.
        if (sent == count / 2) wait_idle();
      end
    end
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset divisor x^3+x+1.
    stall_pct = 20;
    send_message('{1, 0, 1, 1});
    wait_idle();

    // Directed: full 32-bit degree with a standard divisor.
    program_divider(32'h04C1_1DB7, 32'd32);
    send_message('{1, 1});
    wait_idle();

    // Directed: degree zero acts as one; divisor bits above the degree are ignored.
    program_divider(32'hFFFF_FFFF, 32'd0);
    send_message('{1, 1, 0, 1});
    wait_idle();

    // Directed: degree above the maximum saturates, empty divisor, junk high data bits.
    program_divider(32'h0000_0000, 32'hFFFF_FFFF);
    send_message('{1, 0, 0});
    wait_idle();

    // Directed: degree shrinks mid-message, the stored remainder gets trimmed.
    program_divider(32'hFFFF_FFFF, 32'd32);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    wait_idle();
    program_divider(32'h0000_0005, 32'd4);
    send_message('{0, 1});
    wait_idle();

    // Directed: all-zero message leaves a zero remainder.
    send_message('{0, 0, 0});
    wait_idle();

    // Random phases over a spread of divisors and degrees, extremes included.
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: program_divider(32'h0000_1021, 32'd16);
        1: program_divider($urandom(), 32'd1);
        2: program_divider($urandom(), 32'd32);
        3: program_divider($urandom(), 32'd0);
        4: program_divider($urandom(),
                           pcrc_pkg::REM_W'({$urandom_range(32'h03FF_FFFF, 0), 6'd0}
                                            | $urandom_range(63, 33)));
        5: program_divider(32'hFFFF_FFFF, $urandom_range(31, 2));
        6: program_divider(32'h0000_0000, $urandom_range(32, 1));
        default: program_divider($urandom(), $urandom_range(32, 1));
      endcase
      case (phase)
        0: run_phase(50, 10, 10);
        1: run_phase(50, 0, 0);
        2: run_phase(50, 30, 5);
        3: run_phase(50, 5, 30);
        4: run_phase(50, 20, 20);
        5: run_phase(50, 10, 0);
        6: run_phase(50, 0, 15);
        7: run_phase(50, 15, 15);
        default: run_phase(50, 0, 0);
      endcase
    end

    // Flush the open message so the run ends on a marked last bit.
    gap_pct   = 0;
    stall_pct = 0;
    send_bit(1'b0, 1'b1);
    wait_idle();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
